### rtl/uhr_pkg.sv
// Shared constants, types and the hash fold for the identifier hash table.
package uhr_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ADDR_W   = $clog2(ENTRIES + 1);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int HASH_W   = 32;
   localparam int WORD_W   = 64;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int NODE_W   = 5;
   localparam int REC_W    = HASH_W + 2 * WORD_W;

   localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COLL_QUERY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_COLL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NULL      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [WORD_W-1:0] id_high;
      logic [WORD_W-1:0] id_low;
   } record_type;

   // Each word folds to 32 bits by XOR of its halves; the two folds are XORed.
   function automatic logic [HASH_W-1:0] fold_hash(input logic [WORD_W-1:0] hi,
                                                   input logic [WORD_W-1:0] lo);
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
      a = hi[63:32] ^ hi[31:0];
      b = lo[63:32] ^ lo[31:0];
      return a ^ b;
   endfunction

endpackage

### rtl/uhr_req_if.sv
// Request channel: valid/ready handshake with the operation payload.
interface uhr_req_if;
   logic                                valid;
   logic                                ready;
   logic [uhr_pkg::MODE_W-1:0]          mode;
   logic [uhr_pkg::WORD_W-1:0]          uuid_high;
   logic [uhr_pkg::WORD_W-1:0]          uuid_low;
   logic [uhr_pkg::HASH_W-1:0]          query_hash;

   modport source (output valid, mode, uuid_high, uuid_low, query_hash, input ready);
   modport sink   (input valid, mode, uuid_high, uuid_low, query_hash, output ready);
endinterface

### rtl/uhr_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
interface uhr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [uhr_pkg::STATUS_W-1:0]        status;
   logic                                found;
   logic [uhr_pkg::WORD_W-1:0]          found_high;
   logic [uhr_pkg::WORD_W-1:0]          found_low;
   logic [uhr_pkg::HASH_W-1:0]          hash_value;
   logic                                collision_flag;
   logic [uhr_pkg::NODE_W-1:0]          node_count;

   modport source (output valid, status, found, found_high, found_low, hash_value,
                   collision_flag, node_count, input ready);
   modport sink   (input valid, status, found, found_high, found_low, hash_value,
                   collision_flag, node_count, output ready);
endinterface

### rtl/uuid_hash_registry_table.sv
// Top level of the identifier hash table: sequencer, entry scan and response register.
//
//   Channel   Direction  Handshake        Payload
//   req_chan  in         valid / ready    mode, uuid_high, uuid_low, query_hash
//   rsp_chan  out        valid / ready    status, found, found_high, found_low,
//                                         hash_value, collision_flag, node_count
//
// Register, unregister, lookup and collision query walk the table one entry per
// cycle through the registered read port of the record RAM; a walk ends early on
// a hit. Clear, a null identifier and an unused mode skip the walk entirely.
// Reset is synchronous and active high; it empties the table and drops any result.
// A new request is taken only when the sequencer is idle; a result still waiting in
// the response register does not block the next transfer, but the next result
// waits for it.
module uuid_hash_registry_table (
   input logic           clock,
   input logic           reset,
   uhr_req_if.sink       req_chan,
   uhr_rsp_if.source     rsp_chan
);

   uhr_pkg::state_type state_ff, state_in;

   // Latched request.
   logic [uhr_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [uhr_pkg::WORD_W-1:0]   hi_ff, hi_in;
   logic [uhr_pkg::WORD_W-1:0]   lo_ff, lo_in;
   logic [uhr_pkg::HASH_W-1:0]   hv_ff, hv_in;
   logic                         null_ff, null_in;

   // Scan pipeline: address issue, then compare in the next cycle on the registered read data.
   logic [uhr_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [uhr_pkg::IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                         hit_ff, hit_in;
   logic [uhr_pkg::IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [uhr_pkg::WORD_W-1:0]   hit_hi_ff, hit_hi_in;
   logic [uhr_pkg::WORD_W-1:0]   hit_lo_ff, hit_lo_in;
   logic                         free_ff, free_in;
   logic [uhr_pkg::IDX_W-1:0]    free_idx_ff, free_idx_in;

   // Table state held in flip-flops.
   logic [uhr_pkg::ENTRIES-1:0]  valid_ff, valid_in;
   logic [uhr_pkg::ENTRIES-1:0]  coll_ff, coll_in;
   logic [uhr_pkg::CNT_W-1:0]    count_ff, count_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [uhr_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         found_ff, found_in;
   logic [uhr_pkg::WORD_W-1:0]   fhi_ff, fhi_in;
   logic [uhr_pkg::WORD_W-1:0]   flo_ff, flo_in;
   logic [uhr_pkg::HASH_W-1:0]   hval_ff, hval_in;
   logic                         cflag_ff, cflag_in;
   logic [uhr_pkg::NODE_W-1:0]   node_ff, node_in;

   // RAM ports.
   logic                         ram_wr_en;
   logic [uhr_pkg::IDX_W-1:0]    ram_wr_addr;
   uhr_pkg::record_type          ram_wr_rec;
   logic [uhr_pkg::REC_W-1:0]    ram_rd_data;
   uhr_pkg::record_type          rd_rec;

   logic req_xfer;
   logic scan_needed;
   logic issue;
   logic cmp_hit;
   logic scan_last;
   logic out_free;
   logic id_match;

   assign req_chan.ready = (state_ff == uhr_pkg::ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // Only operations that must find a hash or a free entry walk the table.
   always_comb begin
      scan_needed = 1'b0;
      if ((req_chan.mode == uhr_pkg::MODE_REGISTER) ||
          (req_chan.mode == uhr_pkg::MODE_UNREGISTER)) begin
         scan_needed = (req_chan.uuid_high != '0) || (req_chan.uuid_low != '0);
      end else if ((req_chan.mode == uhr_pkg::MODE_LOOKUP) ||
                   (req_chan.mode == uhr_pkg::MODE_COLL_QUERY)) begin
         scan_needed = 1'b1;
      end
   end

   assign issue     = (state_ff == uhr_pkg::ST_SCAN) &&
                      (addr_ff < uhr_pkg::ADDR_W'(uhr_pkg::ENTRIES));
   assign rd_rec    = uhr_pkg::record_type'(ram_rd_data);
   assign cmp_hit   = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_rec.hash == hv_ff);
   assign scan_last = (chk_idx_ff == uhr_pkg::IDX_W'(uhr_pkg::ENTRIES - 1));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign id_match  = (hit_hi_ff == hi_ff) && (hit_lo_ff == lo_ff);

   uhr_ram #(
      .WIDTH (uhr_pkg::REC_W),
      .DEPTH (uhr_pkg::ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_rec),
      .rd_addr (addr_ff[uhr_pkg::IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         uhr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = scan_needed ? uhr_pkg::ST_SCAN : uhr_pkg::ST_FINISH;
            end
         end
         uhr_pkg::ST_SCAN: begin
            // A hash is held by at most one entry, so the walk stops at the first hit.
            if (chk_vld_ff && (cmp_hit || scan_last)) begin
               state_in = uhr_pkg::ST_FINISH;
            end
         end
         uhr_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = uhr_pkg::ST_IDLE;
            end
         end
         default: state_in = uhr_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      mode_in      = mode_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      hv_in        = hv_ff;
      null_in      = null_ff;
      addr_in      = addr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_hi_in    = hit_hi_ff;
      hit_lo_in    = hit_lo_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      coll_in      = coll_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      fhi_in       = fhi_ff;
      flo_in       = flo_ff;
      hval_in      = hval_ff;
      cflag_in     = cflag_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = free_idx_ff;
      ram_wr_rec   = '{hash: hv_ff, id_high: hi_ff, id_low: lo_ff};

      unique case (state_ff)
         uhr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               mode_in = req_chan.mode;
               hi_in   = req_chan.uuid_high;
               lo_in   = req_chan.uuid_low;
               null_in = (req_chan.uuid_high == '0) && (req_chan.uuid_low == '0);
               if ((req_chan.mode == uhr_pkg::MODE_REGISTER) ||
                   (req_chan.mode == uhr_pkg::MODE_UNREGISTER)) begin
                  hv_in = uhr_pkg::fold_hash(req_chan.uuid_high, req_chan.uuid_low);
               end else begin
                  hv_in = req_chan.query_hash;
               end
               addr_in = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
            end
         end

         uhr_pkg::ST_SCAN: begin
            chk_vld_in = issue;
            chk_idx_in = addr_ff[uhr_pkg::IDX_W-1:0];
            if (issue) begin
               addr_in = addr_ff + uhr_pkg::ADDR_W'(1);
            end
            if (cmp_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_hi_in  = rd_rec.id_high;
               hit_lo_in  = rd_rec.id_low;
            end
            // The lowest free entry is the first invalid one the walk passes.
            if (chk_vld_ff && !valid_ff[chk_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end

         uhr_pkg::ST_FINISH: begin
            if (out_free) begin
               status_in = uhr_pkg::STATUS_OK;
               found_in  = 1'b0;
               fhi_in    = '0;
               flo_in    = '0;
               cflag_in  = 1'b0;
               hval_in   = hv_ff;

               priority if (((mode_ff == uhr_pkg::MODE_REGISTER) ||
                             (mode_ff == uhr_pkg::MODE_UNREGISTER)) && null_ff) begin
                  status_in = uhr_pkg::STATUS_NULL;
               end else if (mode_ff == uhr_pkg::MODE_REGISTER) begin
                  if (hit_ff) begin
                     if (id_match) begin
                        status_in = uhr_pkg::STATUS_DUP;
                     end else begin
                        // A different identifier with a held hash marks the holder.
                        status_in           = uhr_pkg::STATUS_COLL;
                        coll_in[hit_idx_ff] = 1'b1;
                     end
                  end else if (!free_ff) begin
                     status_in = uhr_pkg::STATUS_FULL;
                  end else begin
                     ram_wr_en             = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     coll_in[free_idx_ff]  = 1'b0;
                     count_in              = count_ff + uhr_pkg::CNT_W'(1);
                  end
               end else if (mode_ff == uhr_pkg::MODE_UNREGISTER) begin
                  if (hit_ff && id_match) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     coll_in[hit_idx_ff]  = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - uhr_pkg::CNT_W'(1);
                     end
                  end else begin
                     status_in = uhr_pkg::STATUS_NOT_FOUND;
                  end
               end else if (mode_ff == uhr_pkg::MODE_LOOKUP) begin
                  if (hit_ff) begin
                     found_in = 1'b1;
                     fhi_in   = hit_hi_ff;
                     flo_in   = hit_lo_ff;
                  end else begin
                     status_in = uhr_pkg::STATUS_NOT_FOUND;
                  end
               end else if (mode_ff == uhr_pkg::MODE_COLL_QUERY) begin
                  if (hit_ff) begin
                     cflag_in = coll_ff[hit_idx_ff];
                  end else begin
                     status_in = uhr_pkg::STATUS_NOT_FOUND;
                  end
               end else if (mode_ff == uhr_pkg::MODE_CLEAR) begin
                  valid_in = '0;
                  coll_in  = '0;
                  count_in = '0;
               end else begin
                  // Unused modes change nothing and report success.
                  status_in = uhr_pkg::STATUS_OK;
               end

               node_in      = uhr_pkg::NODE_W'(count_in);
               rsp_valid_in = 1'b1;
            end
         end

         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uhr_pkg::ST_IDLE;
         valid_ff     <= '0;
         coll_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         coll_ff      <= coll_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   // Payload and scan bookkeeping.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      hv_ff       <= hv_in;
      null_ff     <= null_in;
      addr_ff     <= addr_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_hi_ff   <= hit_hi_in;
      hit_lo_ff   <= hit_lo_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      fhi_ff      <= fhi_in;
      flo_ff      <= flo_in;
      hval_ff     <= hval_in;
      cflag_ff    <= cflag_in;
      node_ff     <= node_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.found          = found_ff;
   assign rsp_chan.found_high     = fhi_ff;
   assign rsp_chan.found_low      = flo_ff;
   assign rsp_chan.hash_value     = hval_ff;
   assign rsp_chan.collision_flag = cflag_ff;
   assign rsp_chan.node_count     = node_ff;

endmodule

### rtl/uhr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uhr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
